/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the RTL folder.
// Standalone header: no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/belr_pkg.sv */
// Shared types, codes and lookup function for the button edge latch remapper.
// No dependencies.
package belr_pkg;

  // Operation codes
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_LEVEL  = 2'd2;

  // Logical button codes
  localparam logic [3:0] KEY_BACK     = 4'd0;
  localparam logic [3:0] KEY_CONFIRM  = 4'd1;
  localparam logic [3:0] KEY_LEFT     = 4'd2;
  localparam logic [3:0] KEY_RIGHT    = 4'd3;
  localparam logic [3:0] KEY_UP       = 4'd4;
  localparam logic [3:0] KEY_DOWN     = 4'd5;
  localparam logic [3:0] KEY_POWER    = 4'd6;
  localparam logic [3:0] KEY_PAGEBACK = 4'd7;
  localparam logic [3:0] KEY_PAGEFWD  = 4'd8;
  localparam logic [3:0] KEY_NAVNEXT  = 4'd9;
  localparam logic [3:0] KEY_NAVPREV  = 4'd10;
  localparam logic [3:0] KEY_SCR_L    = 4'd11;
  localparam logic [3:0] KEY_SCR_D    = 4'd14;

  // Side layout codes
  localparam logic [1:0] LAYOUT_PREV_NEXT = 2'd0;
  localparam logic [1:0] LAYOUT_NEXT_PREV = 2'd1;

  // Screen orientation codes
  localparam logic [1:0] ORIENT_PORTRAIT = 2'd0;
  localparam logic [1:0] ORIENT_LAND_CW  = 2'd1;
  localparam logic [1:0] ORIENT_INVERTED = 2'd2;
  localparam logic [1:0] ORIENT_LAND_CCW = 2'd3;

  // Register indexes on the APB port (byte address = 4 * index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_FOLLOW  = 3'd0;
  localparam logic [2:0] REG_LAYOUT  = 3'd1;
  localparam logic [2:0] REG_BACK    = 3'd2;
  localparam logic [2:0] REG_CONFIRM = 3'd3;
  localparam logic [2:0] REG_LEFT    = 3'd4;
  localparam logic [2:0] REG_RIGHT   = 3'd5;
  localparam logic [2:0] REG_MAX_AGE = 3'd6;

  // Live vectors carry this many pins
  localparam int unsigned LIVE_W = 8;

  typedef struct packed {
    logic        follow_orientation;
    logic [1:0]  side_layout;
    logic [4:0]  back_pin;
    logic [4:0]  confirm_pin;
    logic [4:0]  left_pin;
    logic [4:0]  right_pin;
    logic [15:0] latch_max_age;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [7:0]  press_edges;
    logic [7:0]  release_edges;
    logic [7:0]  pin_levels;
    logic [3:0]  button;
    logic        edge_kind;
    logic        consume;
    logic [1:0]  screen_orientation;
  } item_t;

  // Physical pin of one logical button
  typedef struct packed {
    logic       ok;
    logic [4:0] pin;
  } pin_t;

  // Request from the query logic to the latch bank
  typedef struct packed {
    logic        upd;
    logic [31:0] now_ms;
    logic [7:0]  press;
    logic [7:0]  release_v;
    logic [7:0]  levels;
    logic        clr;
    logic        clr_press;
    logic [4:0]  clr_pin;
  } lat_req_t;

  // Screen L/R/U/D (0..3) to logical left/right/up/down per orientation
  function automatic logic [3:0] dir_map(input logic [1:0] orient, input logic [1:0] sdir);
    logic [3:0] row [4];
    case (orient)
      ORIENT_PORTRAIT: row = '{KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN};
      ORIENT_LAND_CW:  row = '{KEY_DOWN, KEY_UP, KEY_LEFT, KEY_RIGHT};
      ORIENT_INVERTED: row = '{KEY_RIGHT, KEY_LEFT, KEY_DOWN, KEY_UP};
      ORIENT_LAND_CCW: row = '{KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT};
      default:         row = '{KEY_LEFT, KEY_RIGHT, KEY_UP, KEY_DOWN};
    endcase
    return row[sdir];
  endfunction

endpackage

/* hw/rtl/belr_latch.sv */
// Per-pin press/release latch bank with time stamps, ageing and live vectors.
// Depends on belr_pkg.
module belr_latch #(
  parameter int PIN_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           latch_max_age,
  input  belr_pkg::lat_req_t    req,
  output logic [PIN_COUNT-1:0]  press_latch,
  output logic [PIN_COUNT-1:0]  release_latch,
  output logic [7:0]            live_press,
  output logic [7:0]            live_release,
  output logic [7:0]            live_levels
);
  import belr_pkg::*;

  localparam int IDX_W = $clog2(PIN_COUNT);

  logic [IDX_W-1:0] clr_idx;
  assign clr_idx = req.clr_pin[IDX_W-1:0];

  // Per-pin storage and update
  for (genvar i = 0; i < PIN_COUNT; i++) begin : g_pin
    logic        pe_bit;
    logic        re_bit;
    logic [31:0] press_time;
    logic [31:0] release_time;
    logic        press_aged;
    logic        release_aged;

    if (i < LIVE_W) begin : g_live
      assign pe_bit = req.press[i];
      assign re_bit = req.release_v[i];
    end else begin : g_nolive
      assign pe_bit = 1'b0;
      assign re_bit = 1'b0;
    end

    // Wrapping age against the configured limit
    assign press_aged   = (req.now_ms - press_time) > {16'b0, latch_max_age};
    assign release_aged = (req.now_ms - release_time) > {16'b0, latch_max_age};

    // Latch bits: age out first, then take this frame's edges; consume clears
    always_ff @(posedge clk) begin
      if (rst) begin
        press_latch[i]   <= 1'b0;
        release_latch[i] <= 1'b0;
      end else if (req.upd) begin
        press_latch[i]   <= (press_latch[i] & ~press_aged) | pe_bit;
        release_latch[i] <= (release_latch[i] & ~release_aged) | re_bit;
      end else if (req.clr && (clr_idx == IDX_W'(i))) begin
        if (req.clr_press) begin
          press_latch[i] <= 1'b0;
        end else begin
          release_latch[i] <= 1'b0;
        end
      end
    end

    // Time stamps
    always_ff @(posedge clk) begin
      if (req.upd && pe_bit) begin
        press_time <= req.now_ms;
      end
      if (req.upd && re_bit) begin
        release_time <= req.now_ms;
      end
    end
  end

  // Live vectors of the last frame
  always_ff @(posedge clk) begin
    if (rst) begin
      live_press   <= '0;
      live_release <= '0;
      live_levels  <= '0;
    end else if (req.upd) begin
      live_press   <= req.press;
      live_release <= req.release_v;
      live_levels  <= req.levels;
    end
  end

endmodule

/* hw/rtl/belr_query.sv */
// Query decode: screen direction mapping, composite split, pin lookup and probe.
// Depends on belr_pkg.
module belr_query #(
  parameter int PIN_COUNT = 8,
  parameter int UP_PIN    = 4,
  parameter int DOWN_PIN  = 5,
  parameter int POWER_PIN = 6
) (
  input  belr_pkg::item_t       item,
  input  logic                  item_go,
  input  belr_pkg::cfg_t        cfg,
  input  logic [PIN_COUNT-1:0]  press_latch,
  input  logic [PIN_COUNT-1:0]  release_latch,
  input  logic [7:0]            live_press,
  input  logic [7:0]            live_release,
  input  logic [7:0]            live_levels,
  output logic                  hit,
  output belr_pkg::lat_req_t    req
);
  import belr_pkg::*;

  localparam int IDX_W = $clog2(PIN_COUNT);

  logic       swapped;
  logic [1:0] eff_orient;
  logic [3:0] btn;
  logic [3:0] btn_a;
  logic [3:0] btn_b;
  logic       two;
  pin_t       pa;
  pin_t       pb;
  logic       level;
  logic       hit_a;
  logic       hit_b;
  logic       is_query;

  // Logical button to physical pin
  function automatic pin_t pin_of(input logic [3:0] b, input cfg_t c);
    pin_t p;
    p.ok  = 1'b1;
    p.pin = '0;
    case (b)
      KEY_BACK:     p.pin = c.back_pin;
      KEY_CONFIRM:  p.pin = c.confirm_pin;
      KEY_LEFT:     p.pin = c.left_pin;
      KEY_RIGHT:    p.pin = c.right_pin;
      KEY_UP:       p.pin = 5'(UP_PIN);
      KEY_DOWN:     p.pin = 5'(DOWN_PIN);
      KEY_POWER:    p.pin = 5'(POWER_PIN);
      KEY_PAGEBACK: begin
        if (c.side_layout == LAYOUT_PREV_NEXT) begin
          p.pin = 5'(UP_PIN);
        end else if (c.side_layout == LAYOUT_NEXT_PREV) begin
          p.pin = 5'(DOWN_PIN);
        end else begin
          p.ok = 1'b0;
        end
      end
      KEY_PAGEFWD: begin
        if (c.side_layout == LAYOUT_PREV_NEXT) begin
          p.pin = 5'(DOWN_PIN);
        end else if (c.side_layout == LAYOUT_NEXT_PREV) begin
          p.pin = 5'(UP_PIN);
        end else begin
          p.ok = 1'b0;
        end
      end
      default: p.ok = 1'b0;
    endcase
    // pins beyond the bank have no storage
    if ({1'b0, p.pin} >= 6'(PIN_COUNT)) begin
      p.ok = 1'b0;
    end
    return p;
  endfunction

  // Answer of one pin for the current query
  function automatic logic probe(input pin_t p, input logic lvl, input logic press,
                                 input logic [PIN_COUNT-1:0] plat,
                                 input logic [PIN_COUNT-1:0] rlat,
                                 input logic [7:0] lp, input logic [7:0] lr,
                                 input logic [7:0] ll);
    logic has_live;
    logic live;
    logic lat;
    has_live = (p.pin[4:3] == 2'b00);
    if (lvl) begin
      live = has_live & ll[p.pin[2:0]];
      lat  = 1'b0;
    end else begin
      live = has_live & (press ? lp[p.pin[2:0]] : lr[p.pin[2:0]]);
      lat  = press ? plat[p.pin[IDX_W-1:0]] : rlat[p.pin[IDX_W-1:0]];
    end
    return p.ok & (live | lat);
  endfunction

  // Screen directions and next/previous axis
  always_comb begin
    eff_orient = cfg.follow_orientation ? item.screen_orientation : ORIENT_PORTRAIT;
    swapped    = cfg.follow_orientation &&
                 ((item.screen_orientation == ORIENT_INVERTED) ||
                  (item.screen_orientation == ORIENT_LAND_CCW));
    btn = item.button;
    if ((item.button >= KEY_SCR_L) && (item.button <= KEY_SCR_D)) begin
      btn = dir_map(eff_orient, item.button[1:0] - KEY_SCR_L[1:0]);
    end
  end

  // Composite buttons split into side constituent then front constituent
  always_comb begin
    two   = 1'b0;
    btn_a = btn;
    btn_b = btn;
    case (btn)
      KEY_NAVNEXT: begin
        two   = 1'b1;
        btn_a = swapped ? KEY_UP : KEY_DOWN;
        btn_b = swapped ? KEY_LEFT : KEY_RIGHT;
      end
      KEY_NAVPREV: begin
        two   = 1'b1;
        btn_a = swapped ? KEY_DOWN : KEY_UP;
        btn_b = swapped ? KEY_RIGHT : KEY_LEFT;
      end
      default: two = 1'b0;
    endcase
  end

  // Probe both constituents; the first that answers wins
  always_comb begin
    pa       = pin_of(btn_a, cfg);
    pb       = pin_of(btn_b, cfg);
    level    = (item.op == OP_LEVEL);
    is_query = (item.op == OP_EDGE) || (item.op == OP_LEVEL);
    hit_a    = probe(pa, level, item.edge_kind, press_latch, release_latch,
                     live_press, live_release, live_levels);
    hit_b    = two & probe(pb, level, item.edge_kind, press_latch, release_latch,
                           live_press, live_release, live_levels);
    hit      = is_query & (hit_a | hit_b);
  end

  // Latch bank request: frame update or consume of the answering latch
  always_comb begin
    req.upd       = item_go && (item.op == OP_UPDATE);
    req.now_ms    = item.now_ms;
    req.press     = item.press_edges;
    req.release_v = item.release_edges;
    req.levels    = item.pin_levels;
    req.clr       = item_go && (item.op == OP_EDGE) && item.consume && (hit_a | hit_b);
    req.clr_press = item.edge_kind;
    req.clr_pin   = hit_a ? pa.pin : pb.pin;
  end

endmodule

/* hw/rtl/button_edge_latch_remapper.sv */
// Button edge latch and logical-to-physical remapper, top level.
// Depends on belr_pkg, belr_query and belr_latch.
//
// Takes one transaction per clock on the input channel while the output is not
// stalled and returns exactly one hit per transaction, presented on the result
// channel from the result register. The item sits in an input register, goes
// through a single pass of mapping and probe logic and lands in the result
// register; the latch bank is written on that same edge, so the next item sees
// its effect. Throughput is one item per cycle while the output is not stalled,
// set by that single pass. Frame updates (op 0) age out latches older than
// latch_max_age ms, then latch new edges with now_ms; edge and level queries
// answer for a logical button through the pin roles set on the APB port
// (registers at byte offsets 0x00..0x18). Configure only while idle.
module button_edge_latch_remapper #(
  parameter int PIN_COUNT = 8,
  parameter int UP_PIN    = 4,
  parameter int DOWN_PIN  = 5,
  parameter int POWER_PIN = 6
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] now_ms,
  input  logic [7:0]  press_edges,
  input  logic [7:0]  release_edges,
  input  logic [7:0]  pin_levels,
  input  logic [3:0]  button,
  input  logic        edge_kind,
  input  logic        consume,
  input  logic [1:0]  screen_orientation,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import belr_pkg::*;

  cfg_t                 cfg;
  logic                 cfg_wr;
  logic [2:0]           reg_idx;
  logic                 s1_valid;
  item_t                s1_item;
  logic                 advance;
  logic                 q_hit;
  lat_req_t             req;
  logic [PIN_COUNT-1:0] press_latch;
  logic [PIN_COUNT-1:0] release_latch;
  logic [7:0]           live_press;
  logic [7:0]           live_release;
  logic [7:0]           live_levels;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.follow_orientation <= 1'b0;
      cfg.side_layout        <= LAYOUT_PREV_NEXT;
      cfg.back_pin           <= 5'd0;
      cfg.confirm_pin        <= 5'd1;
      cfg.left_pin           <= 5'd2;
      cfg.right_pin          <= 5'd3;
      cfg.latch_max_age      <= 16'd1000;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FOLLOW:  cfg.follow_orientation <= pwdata[0];
        REG_LAYOUT:  cfg.side_layout        <= pwdata[1:0];
        REG_BACK:    cfg.back_pin           <= pwdata[4:0];
        REG_CONFIRM: cfg.confirm_pin        <= pwdata[4:0];
        REG_LEFT:    cfg.left_pin           <= pwdata[4:0];
        REG_RIGHT:   cfg.right_pin          <= pwdata[4:0];
        REG_MAX_AGE: cfg.latch_max_age      <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_FOLLOW:  prdata = {31'b0, cfg.follow_orientation};
      REG_LAYOUT:  prdata = {30'b0, cfg.side_layout};
      REG_BACK:    prdata = {27'b0, cfg.back_pin};
      REG_CONFIRM: prdata = {27'b0, cfg.confirm_pin};
      REG_LEFT:    prdata = {27'b0, cfg.left_pin};
      REG_RIGHT:   prdata = {27'b0, cfg.right_pin};
      REG_MAX_AGE: prdata = {16'b0, cfg.latch_max_age};
      default:     prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register frees
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.op                 <= op;
      s1_item.now_ms             <= now_ms;
      s1_item.press_edges        <= press_edges;
      s1_item.release_edges      <= release_edges;
      s1_item.pin_levels         <= pin_levels;
      s1_item.button             <= button;
      s1_item.edge_kind          <= edge_kind;
      s1_item.consume            <= consume;
      s1_item.screen_orientation <= screen_orientation;
    end
  end

  // Query decode and probe
  belr_query #(
    .PIN_COUNT (PIN_COUNT),
    .UP_PIN    (UP_PIN),
    .DOWN_PIN  (DOWN_PIN),
    .POWER_PIN (POWER_PIN)
  ) u_query (
    .item          (s1_item),
    .item_go       (advance),
    .cfg           (cfg),
    .press_latch   (press_latch),
    .release_latch (release_latch),
    .live_press    (live_press),
    .live_release  (live_release),
    .live_levels   (live_levels),
    .hit           (q_hit),
    .req           (req)
  );

  // Latch bank
  belr_latch #(
    .PIN_COUNT (PIN_COUNT)
  ) u_latch (
    .clk           (clk),
    .rst           (rst),
    .latch_max_age (cfg.latch_max_age),
    .req           (req),
    .press_latch   (press_latch),
    .release_latch (release_latch),
    .live_press    (live_press),
    .live_release  (live_release),
    .live_levels   (live_levels)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit <= q_hit;
    end
  end

endmodule

/* hw/rtl/belr_checker.sv */
// Port-level checker for the button edge latch remapper, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module belr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit
);

  // Nothing in flight straight after reset, and the input side is open
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!out_valid && in_ready), "not empty after reset")

  // A draining output always leaves room for a new transaction
  `ASSERT_CLK(a_ready_follows, clk, rst, out_ready |-> in_ready, "input stalled while output drains")

  // A full pipeline with a stalled output keeps refusing input until the output is taken
  `ASSERT_CLK(a_full_blocks, clk, rst, (out_valid && !out_ready && !in_ready) |=> (out_valid && !in_ready || out_ready), "pipeline lost an item")

  // A stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(hit)), "result changed while stalled")

endmodule

bind button_edge_latch_remapper belr_checker u_belr_checker (.*);
